// ===== rtl/core/fbdr_pkg.sv =====
// Shared types and constants for the frame buffer dirty-rectangle flush unit.
// Command codes, register indexes, controller states and ctrl/datapath structs.
// No dependencies.
`timescale 1ns / 1ps
`default_nettype none

package fbdr_pkg;

    // Default panel geometry
    localparam int DEF_DISPLAY_WIDTH  = 96;
    localparam int DEF_DISPLAY_HEIGHT = 65;
    localparam int DEF_PAGE_COUNT     = 9;

    // Reset values of the opcode registers
    localparam logic [7:0] RST_PAGE_OPCODE     = 8'hB0;
    localparam logic [7:0] RST_COL_LOW_OPCODE  = 8'h00;
    localparam logic [7:0] RST_COL_HIGH_OPCODE = 8'h10;

    // Input command codes
    typedef enum logic [1:0] {
        CMD_DRAW  = 2'd0,
        CMD_CLEAR = 2'd1,
        CMD_FLUSH = 2'd2,
        CMD_TICK  = 2'd3
    } cmd_code_t;

    // Configuration register indexes
    typedef enum logic [1:0] {
        REG_ROTATION        = 2'd0,
        REG_PAGE_OPCODE     = 2'd1,
        REG_COL_LOW_OPCODE  = 2'd2,
        REG_COL_HIGH_OPCODE = 2'd3
    } reg_index_t;

    // Logical rotation
    typedef enum logic [1:0] {
        ROT_0   = 2'd0,
        ROT_90  = 2'd1,
        ROT_180 = 2'd2,
        ROT_270 = 2'd3
    } rot_t;

    // Flush sequencer phase within one page
    typedef enum logic [1:0] {
        PH_PAGE     = 2'd0,
        PH_COL_LOW  = 2'd1,
        PH_COL_HIGH = 2'd2,
        PH_DATA     = 2'd3
    } phase_t;

    // Controller states
    typedef enum logic [2:0] {
        ST_SWEEP   = 3'd0,
        ST_IDLE    = 3'd1,
        ST_DRAW_RD = 3'd2,
        ST_DRAW_WR = 3'd3,
        ST_DATA    = 3'd4
    } ctrl_state_t;

    // Controller to datapath commands
    typedef struct packed {
        logic draw_load;   // register mapped point of an accepted draw beat
        logic draw_rd;     // read the frame byte under the point
        logic draw_wr;     // write back modified byte, widen dirty box
        logic clear_box;   // dirty box covers whole panel
        logic sweep_step;  // write zero at sweep address, advance
        logic flush_arm;   // latch box, reset box, select first page
        logic tick_cmd;    // emit a command word
        logic data_rd;     // read the next data byte
        logic data_emit;   // emit the data byte read last cycle
    } fbdr_cmd_t;

    // Datapath to controller status
    typedef struct packed {
        logic point_ok;      // registered point lies on the panel
        logic sweep_last;    // sweep address is the last store entry
        logic flush_active;  // sequencer armed
        logic data_phase;    // next tick sends a data byte
        logic out_free;      // output register empty or draining this cycle
    } fbdr_stat_t;

endpackage

`default_nettype wire

// ===== rtl/core/fbdr_ram.sv =====
// Generic single-write, single-read RAM with registered read data.
// No dependencies.
`timescale 1ns / 1ps
`default_nettype none

module fbdr_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 864
) (
    input  wire logic                     clk,
    input  wire logic                     we,
    input  wire logic [$clog2(DEPTH)-1:0] waddr,
    input  wire logic [WIDTH-1:0]         wdata,
    input  wire logic                     re,
    input  wire logic [$clog2(DEPTH)-1:0] raddr,
    output logic      [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    // Write port
    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
    end

    // Registered read port
    always_ff @(posedge clk)
    begin
        if (re)
        begin
            rdata_reg <= mem[raddr];
        end
    end

    assign rdata = rdata_reg;

endmodule

`default_nettype wire

// ===== rtl/core/fbdr_ctrl.sv =====
// Controller state machine: input handshake, store sweep, draw read-modify-write
// and flush tick sequencing. Depends on fbdr_pkg.
`timescale 1ns / 1ps
`default_nettype none

module fbdr_ctrl
    import fbdr_pkg::*;
(
    input  wire logic       clk,
    input  wire logic       rst_n,
    input  wire logic       in_valid,
    input  wire cmd_code_t  in_command,
    input  wire fbdr_stat_t stat,
    output logic            in_ready,
    output fbdr_cmd_t       cmd
);

    ctrl_state_t state_reg;
    ctrl_state_t state_next;

    // State register; reset starts the zeroing sweep
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_SWEEP;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    // Next state and commands
    always_comb
    begin
        state_next = state_reg;
        cmd        = '0;
        in_ready   = 1'b0;
        case (state_reg)
            ST_SWEEP:
            begin
                cmd.sweep_step = 1'b1;
                if (stat.sweep_last)
                begin
                    state_next = ST_IDLE;
                end
            end
            ST_IDLE:
            begin
                in_ready = stat.out_free;
                if (in_valid && stat.out_free)
                begin
                    case (in_command)
                        CMD_DRAW:
                        begin
                            if (!stat.flush_active)
                            begin
                                cmd.draw_load = 1'b1;
                                state_next    = ST_DRAW_RD;
                            end
                        end
                        CMD_CLEAR:
                        begin
                            if (!stat.flush_active)
                            begin
                                cmd.clear_box = 1'b1;
                                state_next    = ST_SWEEP;
                            end
                        end
                        CMD_FLUSH:
                        begin
                            if (!stat.flush_active)
                            begin
                                cmd.flush_arm = 1'b1;
                            end
                        end
                        CMD_TICK:
                        begin
                            if (stat.flush_active)
                            begin
                                if (stat.data_phase)
                                begin
                                    cmd.data_rd = 1'b1;
                                    state_next  = ST_DATA;
                                end
                                else
                                begin
                                    cmd.tick_cmd = 1'b1;
                                end
                            end
                        end
                        default:
                        begin
                        end
                    endcase
                end
            end
            ST_DRAW_RD:
            begin
                if (stat.point_ok)
                begin
                    cmd.draw_rd = 1'b1;
                    state_next  = ST_DRAW_WR;
                end
                else
                begin
                    state_next = ST_IDLE;
                end
            end
            ST_DRAW_WR:
            begin
                cmd.draw_wr = 1'b1;
                state_next  = ST_IDLE;
            end
            ST_DATA:
            begin
                cmd.data_emit = 1'b1;
                state_next    = ST_IDLE;
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

endmodule

`default_nettype wire

// ===== rtl/core/fbdr_datapath.sv =====
// Datapath: configuration registers, rotation map, dirty box, flush sequencer
// counters, frame store addressing and output register. Depends on fbdr_pkg.
`timescale 1ns / 1ps
`default_nettype none

module fbdr_datapath
    import fbdr_pkg::*;
#(
    parameter int DISPLAY_WIDTH  = DEF_DISPLAY_WIDTH,
    parameter int DISPLAY_HEIGHT = DEF_DISPLAY_HEIGHT,
    parameter int PAGE_COUNT     = DEF_PAGE_COUNT,
    localparam int MEM_SIZE      = DISPLAY_WIDTH * PAGE_COUNT,
    localparam int ADDR_W        = $clog2(MEM_SIZE)
) (
    input  wire logic              clk,
    input  wire logic              rst_n,
    // configuration writes
    input  wire logic              cfg_valid,
    input  wire logic [1:0]        cfg_index,
    input  wire logic [7:0]        cfg_data,
    // draw payload
    input  wire logic signed [7:0] in_x,
    input  wire logic signed [7:0] in_y,
    input  wire logic              in_color,
    // controller link
    input  wire fbdr_cmd_t         cmd,
    output fbdr_stat_t             stat,
    // frame store
    output logic                   ram_we,
    output logic [ADDR_W-1:0]      ram_waddr,
    output logic [7:0]             ram_wdata,
    output logic                   ram_re,
    output logic [ADDR_W-1:0]      ram_raddr,
    input  wire logic [7:0]        ram_rdata,
    // result beat
    output logic                   out_valid,
    input  wire logic              out_ready,
    output logic                   out_is_data,
    output logic [7:0]             out_byte,
    output logic                   out_end
);

    localparam logic [7:0] W8       = 8'(DISPLAY_WIDTH);
    localparam logic [7:0] H8       = 8'(DISPLAY_HEIGHT);
    localparam logic [6:0] W1       = 7'(DISPLAY_WIDTH - 1);
    localparam logic [6:0] H1       = 7'(DISPLAY_HEIGHT - 1);
    localparam logic [4:0] PAGES5   = 5'(PAGE_COUNT);
    localparam logic [ADDR_W-1:0] LAST_ADDR = ADDR_W'(MEM_SIZE - 1);

    // First page at or above start that the box touches: {found, page}
    function automatic logic [4:0] page_from(input logic [4:0] start,
                                             input logic [6:0] ymin,
                                             input logic [6:0] ymax);
        logic [4:0] cand;
        logic       found;
        cand  = (start > {1'b0, ymin[6:3]}) ? start : {1'b0, ymin[6:3]};
        found = (cand < PAGES5) && ({1'b0, ymax[6:3]} >= cand);
        return {found, cand[3:0]};
    endfunction

    // Configuration
    rot_t       rotation_reg,    rotation_next;
    logic [7:0] page_op_reg,     page_op_next;
    logic [7:0] col_low_op_reg,  col_low_op_next;
    logic [7:0] col_high_op_reg, col_high_op_next;

    // Registered draw point
    logic [6:0] pt_px_reg, pt_py_reg;
    logic       pt_color_reg, pt_ok_reg;

    // Dirty box and latched box
    logic [6:0] dx_min_reg, dx_min_next, dx_max_reg, dx_max_next;
    logic [6:0] dy_min_reg, dy_min_next, dy_max_reg, dy_max_next;
    logic [6:0] lb_xmin_reg, lb_xmin_next, lb_xmax_reg, lb_xmax_next;
    logic [6:0] lb_ymin_reg, lb_ymin_next, lb_ymax_reg, lb_ymax_next;

    // Flush sequencer
    logic       flush_active_reg, flush_active_next;
    logic [3:0] flush_page_reg,   flush_page_next;
    logic [6:0] flush_col_reg,    flush_col_next;
    phase_t     flush_phase_reg,  flush_phase_next;

    // Zeroing sweep
    logic [ADDR_W-1:0] sweep_addr_reg, sweep_addr_next;

    // Output register
    logic       out_valid_reg, out_valid_next;
    logic       out_is_data_reg, out_end_reg;
    logic [7:0] out_byte_reg;
    logic       ld_out, word_is_data, word_end;
    logic [7:0] word_byte;

    // Mapping and addressing
    logic [6:0]        ix, iy, mpx, mpy;
    logic [7:0]        lw, lh;
    logic              in_ok, map_ok;
    logic [7:0]        bit_mask, rmw_byte;
    logic [ADDR_W-1:0] pt_addr, fl_addr;
    logic [4:0]        next_pg, arm_pg;
    logic              do_next;

    // Rotation map of the incoming point
    always_comb
    begin
        ix = in_x[6:0];
        iy = in_y[6:0];
        if (rotation_reg == ROT_90 || rotation_reg == ROT_270)
        begin
            lw = H8;
            lh = W8;
        end
        else
        begin
            lw = W8;
            lh = H8;
        end
        in_ok = !in_x[7] && !in_y[7] && ({1'b0, ix} < lw) && ({1'b0, iy} < lh);
        case (rotation_reg)
            ROT_90:
            begin
                mpx = iy;
                mpy = H1 - ix;
            end
            ROT_180:
            begin
                mpx = W1 - ix;
                mpy = H1 - iy;
            end
            ROT_270:
            begin
                mpx = W1 - iy;
                mpy = ix;
            end
            default:
            begin
                mpx = ix;
                mpy = iy;
            end
        endcase
        map_ok = in_ok && ({1'b0, mpy[6:3]} < PAGES5);
    end

    // Store addresses and modified byte
    assign pt_addr  = ADDR_W'(pt_py_reg[6:3] * DISPLAY_WIDTH) + ADDR_W'(pt_px_reg);
    assign fl_addr  = ADDR_W'(flush_page_reg * DISPLAY_WIDTH) + ADDR_W'(flush_col_reg);
    assign bit_mask = 8'b1 << pt_py_reg[2:0];
    assign rmw_byte = pt_color_reg ? (ram_rdata | bit_mask) : (ram_rdata & ~bit_mask);

    assign ram_we    = cmd.sweep_step | cmd.draw_wr;
    assign ram_waddr = cmd.sweep_step ? sweep_addr_reg : pt_addr;
    assign ram_wdata = cmd.sweep_step ? 8'h00 : rmw_byte;
    assign ram_re    = cmd.draw_rd | cmd.data_rd;
    assign ram_raddr = cmd.draw_rd ? pt_addr : fl_addr;

    // Page lookups for the next page and for arming
    assign next_pg = page_from({1'b0, flush_page_reg} + 5'd1, lb_ymin_reg, lb_ymax_reg);
    assign arm_pg  = page_from(5'd0, dy_min_reg, dy_max_reg);

    // Configuration writes
    always_comb
    begin
        rotation_next    = rotation_reg;
        page_op_next     = page_op_reg;
        col_low_op_next  = col_low_op_reg;
        col_high_op_next = col_high_op_reg;
        if (cfg_valid)
        begin
            case (reg_index_t'(cfg_index))
                REG_ROTATION:        rotation_next    = rot_t'(cfg_data[1:0]);
                REG_PAGE_OPCODE:     page_op_next     = cfg_data;
                REG_COL_LOW_OPCODE:  col_low_op_next  = cfg_data;
                REG_COL_HIGH_OPCODE: col_high_op_next = cfg_data;
                default:
                begin
                end
            endcase
        end
    end

    // Dirty box, flush sequencer, sweep and output word
    always_comb
    begin
        dx_min_next       = dx_min_reg;
        dx_max_next       = dx_max_reg;
        dy_min_next       = dy_min_reg;
        dy_max_next       = dy_max_reg;
        lb_xmin_next      = lb_xmin_reg;
        lb_xmax_next      = lb_xmax_reg;
        lb_ymin_next      = lb_ymin_reg;
        lb_ymax_next      = lb_ymax_reg;
        flush_active_next = flush_active_reg;
        flush_page_next   = flush_page_reg;
        flush_col_next    = flush_col_reg;
        flush_phase_next  = flush_phase_reg;
        sweep_addr_next   = sweep_addr_reg;
        word_is_data      = 1'b0;
        word_byte         = 8'h00;
        word_end          = 1'b0;
        do_next           = 1'b0;

        // widen box after a draw write
        if (cmd.draw_wr)
        begin
            if (pt_px_reg < dx_min_reg) dx_min_next = pt_px_reg;
            if (pt_px_reg > dx_max_reg) dx_max_next = pt_px_reg;
            if (pt_py_reg < dy_min_reg) dy_min_next = pt_py_reg;
            if (pt_py_reg > dy_max_reg) dy_max_next = pt_py_reg;
        end

        // clear makes the whole panel dirty
        if (cmd.clear_box)
        begin
            dx_min_next = 7'd0;
            dy_min_next = 7'd0;
            if (dx_max_reg < W1) dx_max_next = W1;
            if (dy_max_reg < H1) dy_max_next = H1;
        end

        // sweep wraps back to zero after the last entry
        if (cmd.sweep_step)
        begin
            sweep_addr_next = (sweep_addr_reg == LAST_ADDR) ? '0 : sweep_addr_reg + 1'b1;
        end

        // arm: latch and reset box, pick first page
        if (cmd.flush_arm)
        begin
            lb_xmin_next      = dx_min_reg;
            lb_xmax_next      = dx_max_reg;
            lb_ymin_next      = dy_min_reg;
            lb_ymax_next      = dy_max_reg;
            dx_min_next       = W1;
            dx_max_next       = 7'd0;
            dy_min_next       = H1;
            dy_max_next       = 7'd0;
            flush_phase_next  = PH_PAGE;
            flush_col_next    = 7'd0;
            flush_active_next = arm_pg[4];
            flush_page_next   = arm_pg[4] ? arm_pg[3:0] : 4'd0;
        end

        // command words
        if (cmd.tick_cmd)
        begin
            case (flush_phase_reg)
                PH_PAGE:
                begin
                    word_byte        = page_op_reg | {4'd0, flush_page_reg};
                    flush_phase_next = PH_COL_LOW;
                end
                PH_COL_LOW:
                begin
                    word_byte        = col_low_op_reg | {4'd0, lb_xmin_reg[3:0]};
                    flush_phase_next = PH_COL_HIGH;
                end
                PH_COL_HIGH:
                begin
                    word_byte = col_high_op_reg | {5'd0, lb_xmin_reg[6:4]};
                    if (lb_xmin_reg <= lb_xmax_reg)
                    begin
                        flush_phase_next = PH_DATA;
                        flush_col_next   = lb_xmin_reg;
                    end
                    else
                    begin
                        do_next = 1'b1;
                    end
                end
                default:
                begin
                end
            endcase
        end

        // data byte from the store
        if (cmd.data_emit)
        begin
            word_is_data = 1'b1;
            word_byte    = ({1'b0, flush_col_reg} < W8) ? ram_rdata : 8'h00;
            if (flush_col_reg >= lb_xmax_reg)
            begin
                do_next = 1'b1;
            end
            else
            begin
                flush_col_next = flush_col_reg + 7'd1;
            end
        end

        // advance to next touched page or finish
        if (do_next)
        begin
            flush_phase_next = PH_PAGE;
            flush_col_next   = 7'd0;
            if (!next_pg[4])
            begin
                flush_active_next = 1'b0;
                flush_page_next   = 4'd0;
                word_end          = 1'b1;
            end
            else
            begin
                flush_page_next = next_pg[3:0];
            end
        end
    end

    // Output register handshake
    assign ld_out         = cmd.tick_cmd | cmd.data_emit;
    assign out_valid_next = ld_out ? 1'b1 : (out_ready ? 1'b0 : out_valid_reg);

    // Control state registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            rotation_reg     <= ROT_0;
            page_op_reg      <= RST_PAGE_OPCODE;
            col_low_op_reg   <= RST_COL_LOW_OPCODE;
            col_high_op_reg  <= RST_COL_HIGH_OPCODE;
            dx_min_reg       <= 7'd0;
            dx_max_reg       <= 7'd0;
            dy_min_reg       <= 7'd0;
            dy_max_reg       <= 7'd0;
            lb_xmin_reg      <= 7'd0;
            lb_xmax_reg      <= 7'd0;
            lb_ymin_reg      <= 7'd0;
            lb_ymax_reg      <= 7'd0;
            flush_active_reg <= 1'b0;
            flush_page_reg   <= 4'd0;
            flush_col_reg    <= 7'd0;
            flush_phase_reg  <= PH_PAGE;
            sweep_addr_reg   <= '0;
            out_valid_reg    <= 1'b0;
        end
        else
        begin
            rotation_reg     <= rotation_next;
            page_op_reg      <= page_op_next;
            col_low_op_reg   <= col_low_op_next;
            col_high_op_reg  <= col_high_op_next;
            dx_min_reg       <= dx_min_next;
            dx_max_reg       <= dx_max_next;
            dy_min_reg       <= dy_min_next;
            dy_max_reg       <= dy_max_next;
            lb_xmin_reg      <= lb_xmin_next;
            lb_xmax_reg      <= lb_xmax_next;
            lb_ymin_reg      <= lb_ymin_next;
            lb_ymax_reg      <= lb_ymax_next;
            flush_active_reg <= flush_active_next;
            flush_page_reg   <= flush_page_next;
            flush_col_reg    <= flush_col_next;
            flush_phase_reg  <= flush_phase_next;
            sweep_addr_reg   <= sweep_addr_next;
            out_valid_reg    <= out_valid_next;
        end
    end

    // Payload registers
    always_ff @(posedge clk)
    begin
        if (cmd.draw_load)
        begin
            pt_px_reg    <= mpx;
            pt_py_reg    <= mpy;
            pt_color_reg <= in_color;
            pt_ok_reg    <= map_ok;
        end
        if (ld_out)
        begin
            out_is_data_reg <= word_is_data;
            out_byte_reg    <= word_byte;
            out_end_reg     <= word_end;
        end
    end

    // Status to controller and result beat
    assign stat.point_ok     = pt_ok_reg;
    assign stat.sweep_last   = (sweep_addr_reg == LAST_ADDR);
    assign stat.flush_active = flush_active_reg;
    assign stat.data_phase   = (flush_phase_reg == PH_DATA);
    assign stat.out_free     = !out_valid_reg || out_ready;

    assign out_valid   = out_valid_reg;
    assign out_is_data = out_is_data_reg;
    assign out_byte    = out_byte_reg;
    assign out_end     = out_end_reg;

`ifndef NO_ASSERTIONS
    // idle sequencer always sits at the start of a page
    a_idle_seq: assert property (@(posedge clk) disable iff (!rst_n)
        !flush_active_reg |-> (flush_phase_reg == PH_PAGE && flush_col_reg == 7'd0))
        else $error("sequencer not parked while idle");

    // armed sequencer points at a real page
    a_page_range: assert property (@(posedge clk) disable iff (!rst_n)
        flush_active_reg |-> ({1'b0, flush_page_reg} < PAGES5))
        else $error("flush page beyond store");

    // a word is never loaded over one that is not being taken
    a_out_slot: assert property (@(posedge clk) disable iff (!rst_n)
        ld_out |-> (!out_valid_reg || out_ready))
        else $error("result overwritten");

    // data byte is emitted in the cycle after its store read
    a_data_lat: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.data_emit |-> $past(cmd.data_rd))
        else $error("data emitted without read");

    // write-back only for points on the panel
    a_draw_ok: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.draw_wr |-> pt_ok_reg)
        else $error("draw write of dropped point");
`endif

endmodule

`default_nettype wire

// ===== rtl/core/framebuffer_dirty_rect_flush_unit.sv =====
// Top level of the frame buffer dirty-rectangle flush unit.
// Instantiates fbdr_ram, fbdr_ctrl and fbdr_datapath; depends on fbdr_pkg.
//
// Monochrome page-organized frame buffer (one byte per column per 8-row page)
// with a dirty bounding box and a flush sequencer that emits one controller
// word per tick beat while a flush is active. After reset, and after every
// clear beat, the frame store is zeroed by a sweep over all
// DISPLAY_WIDTH*PAGE_COUNT entries (864 at the default geometry) during which
// no input beat is accepted; configuration writes are taken at any time. A
// draw beat that lands on the panel goes through the point map register, a
// store read and a write-back through the single write port; a draw beat
// that falls off the panel ends at the point map register. A tick that sends
// a data byte waits for the registered read of the frame store before the
// byte is emitted. A result waiting in the output register holds back every
// input beat until that result is taken.
`timescale 1ns / 1ps
`default_nettype none

module framebuffer_dirty_rect_flush_unit
    import fbdr_pkg::*;
#(
    parameter int DISPLAY_WIDTH  = DEF_DISPLAY_WIDTH,
    parameter int DISPLAY_HEIGHT = DEF_DISPLAY_HEIGHT,
    parameter int PAGE_COUNT     = DEF_PAGE_COUNT
) (
    input  wire logic        clk,
    input  wire logic        rst_n,
    // input stream
    input  wire logic        s_axis_tvalid,
    output logic             s_axis_tready,
    input  wire logic [23:0] s_axis_tdata,   // x[7:0], y[15:8], color[16], zero pad
    input  wire logic [1:0]  s_axis_tuser,   // command[1:0]
    // output stream
    output logic             m_axis_tvalid,
    input  wire logic        m_axis_tready,
    output logic [7:0]       m_axis_tdata,   // word_byte[7:0]
    output logic [0:0]       m_axis_tuser,   // is_data[0]
    output logic             m_axis_tlast,   // flush_end
    // configuration write channel
    input  wire logic        cfg_valid,
    output logic             cfg_ready,
    input  wire logic [1:0]  cfg_index,
    input  wire logic [7:0]  cfg_data
);

    localparam int MEM_SIZE = DISPLAY_WIDTH * PAGE_COUNT;
    localparam int ADDR_W   = $clog2(MEM_SIZE);

    fbdr_cmd_t         cmd;
    fbdr_stat_t        stat;
    logic              ram_we, ram_re;
    logic [ADDR_W-1:0] ram_waddr, ram_raddr;
    logic [7:0]        ram_wdata, ram_rdata;
    logic              out_is_data;

    // Configuration is always accepted
    assign cfg_ready = 1'b1;

    // Frame store
    fbdr_ram #(
        .WIDTH (8),
        .DEPTH (MEM_SIZE)
    ) u_ram (
        .clk   (clk),
        .we    (ram_we),
        .waddr (ram_waddr),
        .wdata (ram_wdata),
        .re    (ram_re),
        .raddr (ram_raddr),
        .rdata (ram_rdata)
    );

    // Controller
    fbdr_ctrl u_ctrl (
        .clk        (clk),
        .rst_n      (rst_n),
        .in_valid   (s_axis_tvalid),
        .in_command (cmd_code_t'(s_axis_tuser)),
        .stat       (stat),
        .in_ready   (s_axis_tready),
        .cmd        (cmd)
    );

    // Datapath
    fbdr_datapath #(
        .DISPLAY_WIDTH  (DISPLAY_WIDTH),
        .DISPLAY_HEIGHT (DISPLAY_HEIGHT),
        .PAGE_COUNT     (PAGE_COUNT)
    ) u_dp (
        .clk         (clk),
        .rst_n       (rst_n),
        .cfg_valid   (cfg_valid),
        .cfg_index   (cfg_index),
        .cfg_data    (cfg_data),
        .in_x        (s_axis_tdata[7:0]),
        .in_y        (s_axis_tdata[15:8]),
        .in_color    (s_axis_tdata[16]),
        .cmd         (cmd),
        .stat        (stat),
        .ram_we      (ram_we),
        .ram_waddr   (ram_waddr),
        .ram_wdata   (ram_wdata),
        .ram_re      (ram_re),
        .ram_raddr   (ram_raddr),
        .ram_rdata   (ram_rdata),
        .out_valid   (m_axis_tvalid),
        .out_ready   (m_axis_tready),
        .out_is_data (out_is_data),
        .out_byte    (m_axis_tdata),
        .out_end     (m_axis_tlast)
    );

    assign m_axis_tuser = out_is_data;

endmodule

`default_nettype wire

// ===== dv/tb_framebuffer_dirty_rect_flush_unit.sv =====
// Self-checking testbench for framebuffer_dirty_rect_flush_unit: draw, clear, flush and tick
// beats against a local model of the page store, the dirty box and the flush sequencer.
// Depends on fbdr_pkg and the RTL under rtl/core.
`timescale 1ns / 1ps

module tb_framebuffer_dirty_rect_flush_unit;
    import fbdr_pkg::*;

    localparam int FB_W          = DEF_DISPLAY_WIDTH;
    localparam int FB_H          = DEF_DISPLAY_HEIGHT;
    localparam int FB_PAGES      = DEF_PAGE_COUNT;
    localparam int FB_BYTES      = FB_W * FB_PAGES;
    localparam int NO_PAGE       = -1;
    // clear sweep walks the whole store; leave margin for a draw in flight
    localparam int SETTLE_CYCLES = FB_BYTES + 128;
    localparam int QUIET_LIMIT   = 5000;
    localparam int N_PHASES      = 6;
    localparam int PHASE_BEATS   = 50;
    localparam int MAX_REPORTS   = 60;

    typedef struct packed {
        cmd_code_t  cmd;
        logic [7:0] x;
        logic [7:0] y;
        logic       color;
    } fb_beat_t;

    typedef struct packed {
        logic       is_data;
        logic [7:0] data_byte;
        logic       last;
    } panel_word_t;

    logic        clk;
    logic        rst_n         = 1'b0;
    logic        s_axis_tvalid = 1'b0;
    logic        s_axis_tready;
    logic [23:0] s_axis_tdata  = '0;
    logic [1:0]  s_axis_tuser  = CMD_TICK;
    logic        m_axis_tvalid;
    logic        m_axis_tready = 1'b0;
    logic [7:0]  m_axis_tdata;
    logic [0:0]  m_axis_tuser;
    logic        m_axis_tlast;
    logic        cfg_valid     = 1'b0;
    logic        cfg_ready;
    reg_index_t  cfg_index     = REG_ROTATION;
    logic [7:0]  cfg_data      = '0;

    framebuffer_dirty_rect_flush_unit #(
        .DISPLAY_WIDTH  (FB_W),
        .DISPLAY_HEIGHT (FB_H),
        .PAGE_COUNT     (FB_PAGES)
    ) u_dut (
        .clk           (clk),
        .rst_n         (rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tuser  (m_axis_tuser),
        .m_axis_tlast  (m_axis_tlast),
        .cfg_valid     (cfg_valid),
        .cfg_ready     (cfg_ready),
        .cfg_index     (cfg_index),
        .cfg_data      (cfg_data)
    );

    initial
    begin
        clk = 1'b0;
        forever #1 clk = ~clk;
    end

    // ------------------------------------------------------------------
    // Panel model: store, dirty box, latched span, sequencer, registers
    // ------------------------------------------------------------------
    logic [7:0] frame_mirror [FB_BYTES];
    logic [6:0] box_xmin  = '0;
    logic [6:0] box_xmax  = '0;
    logic [6:0] box_ymin  = '0;
    logic [6:0] box_ymax  = '0;
    logic [6:0] span_xmin = '0;
    logic [6:0] span_xmax = '0;
    logic [6:0] span_ymin = '0;
    logic [6:0] span_ymax = '0;
    logic       seq_busy  = 1'b0;
    logic [3:0] seq_page  = '0;
    logic [6:0] seq_col   = '0;
    phase_t     seq_phase = PH_PAGE;
    rot_t       rot       = ROT_0;
    logic [7:0] page_op   = RST_PAGE_OPCODE;
    logic [7:0] col_lo_op = RST_COL_LOW_OPCODE;
    logic [7:0] col_hi_op = RST_COL_HIGH_OPCODE;

    fb_beat_t    beats_pending [$];
    panel_word_t words_due [$];
    int          n_queued    = 0;
    int          n_taken     = 0;
    int          errors      = 0;
    int          clears_left = 0;

    function automatic void wipe_frame();
        for (int i = 0; i < FB_BYTES; i++)
            frame_mirror[i] = 8'h00;
    endfunction

    // logical width or height under the current rotation
    function automatic int logical_limit(bit want_h);
        bit turned;
        turned = (rot == ROT_90 || rot == ROT_270);
        return (want_h ^ turned) ? FB_H : FB_W;
    endfunction

    // first page at or above start that the latched span touches
    function automatic int next_touched_page(int start);
        for (int p = start; p < FB_PAGES; p++)
        begin
            if (int'(span_ymin) >= (p + 1) * 8)
                continue;
            return (int'(span_ymax) < p * 8) ? NO_PAGE : p;
        end
        return NO_PAGE;
    endfunction

    // step to the next touched page; returns 1 when the flush is over
    function automatic bit advance_page();
        int p;
        p = next_touched_page(int'(seq_page) + 1);
        seq_phase = PH_PAGE;
        seq_col   = '0;
        if (p == NO_PAGE)
        begin
            seq_busy = 1'b0;
            seq_page = '0;
            return 1'b1;
        end
        seq_page = 4'(p);
        return 1'b0;
    endfunction

    function automatic void plot_point(int x, int y, logic color);
        int px, py, addr;
        if (x < 0 || x >= logical_limit(0) || y < 0 || y >= logical_limit(1))
            return;
        case (rot)
            ROT_90:  begin px = y;            py = FB_H - 1 - x; end
            ROT_180: begin px = FB_W - 1 - x; py = FB_H - 1 - y; end
            ROT_270: begin px = FB_W - 1 - y; py = x;            end
            default: begin px = x;            py = y;            end
        endcase
        if (px < 0 || px >= FB_W || py < 0 || py >= FB_H || py / 8 >= FB_PAGES)
            return;
        addr = px + (py / 8) * FB_W;
        frame_mirror[addr][py % 8] = color;
        if (px < int'(box_xmin)) box_xmin = 7'(px);
        if (px > int'(box_xmax)) box_xmax = 7'(px);
        if (py < int'(box_ymin)) box_ymin = 7'(py);
        if (py > int'(box_ymax)) box_ymax = 7'(py);
    endfunction

    // apply one accepted beat; returns 1 with the word a tick sends
    function automatic bit advance_panel_model(fb_beat_t b, output panel_word_t w);
        int p, addr;
        w = '0;
        if (b.cmd != CMD_TICK)
        begin
            // busy sequencer drops everything but ticks
            if (seq_busy)
                return 1'b0;
            case (b.cmd)
                CMD_DRAW:
                    plot_point(int'($signed(b.x)), int'($signed(b.y)), b.color);
                CMD_CLEAR:
                begin
                    wipe_frame();
                    box_xmin = '0;
                    box_ymin = '0;
                    if (box_xmax < 7'(FB_W - 1)) box_xmax = 7'(FB_W - 1);
                    if (box_ymax < 7'(FB_H - 1)) box_ymax = 7'(FB_H - 1);
                end
                default:
                begin
                    // arm: latch box, reset box, pick first page
                    span_xmin = box_xmin;
                    span_xmax = box_xmax;
                    span_ymin = box_ymin;
                    span_ymax = box_ymax;
                    box_xmin  = 7'(FB_W - 1);
                    box_xmax  = '0;
                    box_ymin  = 7'(FB_H - 1);
                    box_ymax  = '0;
                    p         = next_touched_page(0);
                    seq_phase = PH_PAGE;
                    seq_col   = '0;
                    seq_busy  = (p != NO_PAGE);
                    seq_page  = (p == NO_PAGE) ? 4'd0 : 4'(p);
                end
            endcase
            return 1'b0;
        end
        if (!seq_busy)
            return 1'b0;
        case (seq_phase)
            PH_PAGE:
            begin
                w.data_byte = page_op | {4'd0, seq_page};
                seq_phase   = PH_COL_LOW;
            end
            PH_COL_LOW:
            begin
                w.data_byte = col_lo_op | {4'd0, span_xmin[3:0]};
                seq_phase   = PH_COL_HIGH;
            end
            PH_COL_HIGH:
            begin
                w.data_byte = col_hi_op | {5'd0, span_xmin[6:4]};
                if (span_xmin <= span_xmax)
                begin
                    seq_phase = PH_DATA;
                    seq_col   = span_xmin;
                end
                else
                    w.last = advance_page();
            end
            default:
            begin
                w.is_data   = 1'b1;
                addr        = int'(seq_page) * FB_W + int'(seq_col);
                w.data_byte = (addr < FB_BYTES && seq_col < FB_W) ? frame_mirror[addr] : 8'h00;
                if (seq_col >= span_xmax)
                    w.last = advance_page();
                else
                    seq_col = seq_col + 7'd1;
            end
        endcase
        return 1'b1;
    endfunction

    // ------------------------------------------------------------------
    // Idle and stall lengths: mostly short, a few long, calm stretches
    // ------------------------------------------------------------------
    function automatic int unsigned pick_gap(bit calm);
        int unsigned r;
        if (calm)
            return 0;
        r = $urandom_range(0, 99);
        if (r < 55) return 0;
        if (r < 85) return $urandom_range(1, 3);
        if (r < 97) return $urandom_range(4, 12);
        return $urandom_range(20, 60);
    endfunction

    // input driver: one beat per pop, gap after each beat
    int unsigned send_wait = 0;
    bit          send_calm = 1'b0;

    always @(posedge clk)
    begin : drive_in
        fb_beat_t b;
        if (!rst_n)
        begin
            s_axis_tvalid <= 1'b0;
            send_wait     <= 0;
        end
        else if (!s_axis_tvalid || s_axis_tready)
        begin
            if (send_wait != 0)
            begin
                s_axis_tvalid <= 1'b0;
                send_wait     <= send_wait - 1;
            end
            else if (beats_pending.size() != 0)
            begin
                b = beats_pending.pop_front();
                s_axis_tvalid <= 1'b1;
                s_axis_tuser  <= b.cmd;
                s_axis_tdata  <= {7'd0, b.color, b.y, b.x};
                send_wait     <= pick_gap(send_calm);
                if ($urandom_range(0, 99) == 0)
                    send_calm <= !send_calm;
            end
            else
                s_axis_tvalid <= 1'b0;
        end
    end

    // output back-pressure
    int unsigned recv_wait = 0;
    bit          recv_calm = 1'b0;

    always @(posedge clk)
    begin : drive_ready
        int unsigned stall;
        if (!rst_n)
        begin
            m_axis_tready <= 1'b0;
            recv_wait     <= 0;
        end
        else if (recv_wait != 0)
        begin
            m_axis_tready <= 1'b0;
            recv_wait     <= recv_wait - 1;
        end
        else
        begin
            stall = pick_gap(recv_calm);
            m_axis_tready <= (stall == 0);
            recv_wait     <= (stall == 0) ? 0 : stall - 1;
            if ($urandom_range(0, 99) == 0)
                recv_calm <= !recv_calm;
        end
    end

    // input monitor: every accepted beat goes through the model
    always @(posedge clk)
    begin : watch_in
        fb_beat_t    b;
        panel_word_t w;
        if (rst_n && s_axis_tvalid && s_axis_tready)
        begin
            b.cmd   = cmd_code_t'(s_axis_tuser);
            b.x     = s_axis_tdata[7:0];
            b.y     = s_axis_tdata[15:8];
            b.color = s_axis_tdata[16];
            n_taken++;
            if (advance_panel_model(b, w))
                words_due.push_back(w);
        end
    end

    task automatic note_mismatch(string field, int exp_v, int act_v);
        errors++;
        if (errors <= MAX_REPORTS)
            $error("%s: expected 0x%0h, actual 0x%0h", field, exp_v, act_v);
    endtask

    // output monitor: each word against the oldest expected word
    always @(posedge clk)
    begin : watch_out
        panel_word_t w;
        if (rst_n && m_axis_tvalid && m_axis_tready)
        begin
            if (words_due.size() == 0)
            begin
                errors++;
                if (errors <= MAX_REPORTS)
                    $error("unexpected panel word 0x%02h", m_axis_tdata);
            end
            else
            begin
                w = words_due.pop_front();
                if (w.is_data !== m_axis_tuser[0])
                    note_mismatch("is_data", int'(w.is_data), int'(m_axis_tuser[0]));
                if (w.data_byte !== m_axis_tdata)
                    note_mismatch("word_byte", int'(w.data_byte), int'(m_axis_tdata));
                if (w.last !== m_axis_tlast)
                    note_mismatch("flush_end", int'(w.last), int'(m_axis_tlast));
            end
        end
    end

    // watchdog on cycles without any beat moving
    int quiet_cycles = 0;

    always @(posedge clk)
    begin
        if (!rst_n || (s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready) ||
            (cfg_valid && cfg_ready))
            quiet_cycles <= 0;
        else if (quiet_cycles >= QUIET_LIMIT)
        begin
            $display("*** FAILED ***");
            $finish;
        end
        else
            quiet_cycles <= quiet_cycles + 1;
    end

    // ------------------------------------------------------------------
    // Stimulus helpers
    // ------------------------------------------------------------------
    task automatic queue_beat(cmd_code_t c, int x, int y, int color);
        fb_beat_t b;
        b.cmd   = c;
        b.x     = 8'(x);
        b.y     = 8'(y);
        b.color = color[0];
        beats_pending.push_back(b);
        n_queued++;
    endtask

    task automatic sync_sender();
        while (n_taken != n_queued)
            @(posedge clk);
    endtask

    // stimulus waits until every queued beat is taken and every expected word is out
    task automatic drain_words();
        sync_sender();
        while (words_due.size() != 0)
            @(posedge clk);
    endtask

    // tick until the sequencer is idle, with dropped beats mixed in
    task automatic finish_flush();
        sync_sender();
        while (seq_busy)
        begin
            repeat ($urandom_range(4, 40))
            begin
                if ($urandom_range(0, 9) == 0)
                    queue_beat($urandom_range(0, 1) ? CMD_DRAW : CMD_FLUSH,
                               $urandom, $urandom, $urandom);
                queue_beat(CMD_TICK, $urandom, $urandom, $urandom);
            end
            sync_sender();
        end
    endtask

    // block idle: no beat, no word, clear sweep done
    task automatic settle();
        drain_words();
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    task automatic write_reg(reg_index_t idx, logic [7:0] val);
        @(posedge clk);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= val;
        @(posedge clk);
        while (!cfg_ready)
            @(posedge clk);
        cfg_valid <= 1'b0;
        case (idx)
            REG_ROTATION:       rot       = rot_t'(val[1:0]);
            REG_PAGE_OPCODE:    page_op   = val;
            REG_COL_LOW_OPCODE: col_lo_op = val;
            default:            col_hi_op = val;
        endcase
    endtask

    // a few draws around one logical point
    task automatic queue_cluster(int n, int spread);
        int cx, cy;
        cx = $urandom_range(0, logical_limit(0) - 1);
        cy = $urandom_range(0, logical_limit(1) - 1);
        repeat (n)
            queue_beat(CMD_DRAW, cx + $urandom_range(0, spread), cy + $urandom_range(0, spread),
                       $urandom_range(0, 3) != 0);
    endtask

    task automatic random_sequence();
        int kind, spread, lw, lh;
        kind = $urandom_range(0, 99);
        lw   = logical_limit(0);
        lh   = logical_limit(1);
        if (kind < 50)
        begin
            // draws then a full flush; mostly small boxes
            spread = ($urandom_range(0, 19) == 0) ? $urandom_range(8, 60) : $urandom_range(0, 7);
            finish_flush();
            queue_cluster($urandom_range(1, 8), spread);
            queue_beat(CMD_FLUSH, $urandom, $urandom, $urandom);
            finish_flush();
        end
        else if (kind < 58)
        begin
            // flush with nothing drawn since the last one
            finish_flush();
            queue_beat(CMD_FLUSH, $urandom, $urandom, $urandom);
            finish_flush();
            queue_beat(CMD_FLUSH, $urandom, $urandom, $urandom);
            repeat ($urandom_range(1, 3))
                queue_beat(CMD_TICK, $urandom, $urandom, $urandom);
        end
        else if (kind < 82)
        begin
            // noise: any field value, no clear
            repeat ($urandom_range(1, 12))
            begin
                case ($urandom_range(0, 9))
                    0:       queue_beat(CMD_FLUSH, $urandom, $urandom, $urandom);
                    1, 2, 3: queue_beat(CMD_TICK, $urandom, $urandom, $urandom);
                    default: queue_beat(CMD_DRAW, $urandom, $urandom, $urandom);
                endcase
            end
        end
        else if (kind < 94)
        begin
            // points on and just past the logical edges
            finish_flush();
            repeat ($urandom_range(1, 4))
            begin
                case ($urandom_range(0, 3))
                    0: queue_beat(CMD_DRAW, -1, $urandom_range(0, lh - 1), $urandom);
                    1: queue_beat(CMD_DRAW, lw, $urandom_range(0, lh - 1), $urandom);
                    2: queue_beat(CMD_DRAW, $urandom_range(0, lw - 1),
                                  $urandom_range(0, 1) ? -1 : lh, $urandom);
                    default: queue_beat(CMD_DRAW, lw - 1, lh - 1, $urandom);
                endcase
            end
        end
        else if (kind < 97 && clears_left > 0)
        begin
            // clear makes the next flush cover the whole panel
            clears_left--;
            finish_flush();
            queue_beat(CMD_CLEAR, $urandom, $urandom, $urandom);
            queue_cluster($urandom_range(1, 6), 7);
            queue_beat(CMD_FLUSH, $urandom, $urandom, $urandom);
            finish_flush();
        end
        else
            drain_words();
    endtask

    // ------------------------------------------------------------------
    // Main sequence
    // ------------------------------------------------------------------
    initial
    begin : stimulus
        int         phase_end;
        logic [1:0] r;
        logic [7:0] v_pg, v_lo, v_hi;

        wipe_frame();
        repeat (9) @(posedge clk);
        rst_n <= 1'b1;

        // directed: idle tick, flush of the reset box, empty flush
        queue_beat(CMD_TICK, 0, 0, 0);
        queue_beat(CMD_FLUSH, 0, 0, 0);
        repeat (4) queue_beat(CMD_TICK, 8'hFF, 8'hFF, 1);
        queue_beat(CMD_TICK, 0, 0, 0);
        queue_beat(CMD_FLUSH, 0, 0, 0);
        queue_beat(CMD_TICK, 0, 0, 0);
        // clear, corner and out-of-range draws, bit set then cleared
        queue_beat(CMD_CLEAR, 0, 0, 0);
        queue_beat(CMD_DRAW, 0, 0, 1);
        queue_beat(CMD_DRAW, FB_W - 1, FB_H - 1, 1);
        queue_beat(CMD_DRAW, FB_W - 1, FB_H - 1, 0);
        queue_beat(CMD_DRAW, -128, -128, 1);
        queue_beat(CMD_DRAW, 127, 127, 1);
        queue_beat(CMD_DRAW, FB_W, 0, 1);
        queue_beat(CMD_DRAW, 0, FB_H, 1);
        queue_beat(CMD_DRAW, -1, 5, 1);
        queue_beat(CMD_DRAW, 40, 33, 1);
        queue_beat(CMD_FLUSH, 0, 0, 0);
        // draw, clear and flush dropped while busy
        repeat (3) queue_beat(CMD_TICK, 0, 0, 0);
        queue_beat(CMD_DRAW, 1, 1, 1);
        queue_beat(CMD_CLEAR, 0, 0, 0);
        queue_beat(CMD_FLUSH, 0, 0, 0);
        finish_flush();

        // random phases, registers rewritten between them
        for (int ph = 0; ph < N_PHASES; ph++)
        begin
            if (ph != 0)
            begin
                settle();
                v_pg = 8'($urandom);
                v_lo = 8'($urandom);
                v_hi = 8'($urandom);
                r    = 2'($urandom);
                case (ph)
                    1: begin r = ROT_90;  v_pg = 8'h00; v_lo = 8'h00; v_hi = 8'h00; end
                    2: begin r = ROT_180; v_pg = 8'hFF; v_lo = 8'hFF; v_hi = 8'hFF; end
                    3: r = ROT_270;
                    4: r = ROT_0;
                    default: ;
                endcase
                write_reg(REG_ROTATION, {6'($urandom), r});
                write_reg(REG_PAGE_OPCODE, v_pg);
                write_reg(REG_COL_LOW_OPCODE, v_lo);
                write_reg(REG_COL_HIGH_OPCODE, v_hi);
            end
            phase_end = n_queued + PHASE_BEATS;
            while (n_queued < phase_end)
                random_sequence();
        end

        settle();
        if (errors == 0)
            $display("*** PASSED ***");
        else
            $display("*** FAILED ***");
        $finish;
    end

endmodule
